// ===== rtl/csem_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting semaphore package
// Shared types, codes and constants for the counting semaphore with a
// first-in first-out queue of waiters.
// ----------------------------------------------------------------------------
package csem_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int COUNT_W             = 8;
   localparam int ID_W                = 8;
   localparam int WAITERS_W           = 5;
   localparam int CSR_ADDR_W          = 3;
   localparam int CSR_DATA_W          = 32;

   localparam logic [COUNT_W-1:0] INIT_COUNT_RESET = 8'd1;

   typedef enum logic {
      CMD_ACQUIRE = 1'b0,
      CMD_RELEASE = 1'b1
   } command_type;

   typedef enum logic [2:0] {
      STS_GRANTED       = 3'd0,
      STS_QUEUED        = 3'd1,
      STS_REJECTED      = 3'd2,
      STS_RETURNED      = 3'd3,
      STS_HANDED        = 3'd4,
      STS_RELEASE_ERROR = 3'd5
   } status_type;

   typedef enum logic {
      CS_IDLE = 1'b0,
      CS_EXEC = 1'b1
   } ctrl_state_type;

   localparam logic CSR_REG_INITIAL_COUNT = 1'b0;

   typedef struct packed {
      logic load_req;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic slot_free;
   } dp_stat_type;

endpackage

// ===== rtl/counting_semaphore_fifo_waiters_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting semaphore with waiter queue, top level
//
// Channel   Ports      Direction  Carries
// req       req_*      in         command, requester_id
// rsp       rsp_*      out        status, grant_valid, grant_id, all_free,
//                                  waiter_count
// csr       csr_*      in/out     initial_count at byte address 0
//
// Each transaction captures the request and reads the head of the waiter
// queue memory, then in a later step updates the pool and queue.
// The result register lets the next request be captured while a result waits.
// A stalled result holds the transaction in execution until the register frees.
// Reset is synchronous; it loads one permit and empties the queue.
// ----------------------------------------------------------------------------
module counting_semaphore_fifo_waiters_top
   import csem_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_command,
   input  logic [ID_W-1:0]       req_requester_id,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_status,
   output logic                  rsp_grant_valid,
   output logic [ID_W-1:0]       rsp_grant_id,
   output logic                  rsp_all_free,
   output logic [WAITERS_W-1:0]  rsp_waiter_count,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   dp_cmd_type         dp_cmd;
   dp_stat_type        dp_stat;
   logic               cfg_we;
   logic [COUNT_W-1:0] cfg_initial_count;

   assign csr_pready = 1'b1;
   assign cfg_we     = csr_psel && csr_penable && csr_pwrite && csr_pready
                       && (csr_paddr[2] == CSR_REG_INITIAL_COUNT);

   always_comb begin
      if (csr_paddr[2] == CSR_REG_INITIAL_COUNT) begin
         csr_prdata = {{(CSR_DATA_W-COUNT_W){1'b0}}, cfg_initial_count};
      end else begin
         csr_prdata = '0;
      end
   end

   csem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_stat   (dp_stat),
      .dp_cmd    (dp_cmd)
   );

   csem_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .dp_cmd            (dp_cmd),
      .dp_stat           (dp_stat),
      .req_command       (req_command),
      .req_requester_id  (req_requester_id),
      .cfg_we            (cfg_we),
      .cfg_wdata         (csr_pwdata[COUNT_W-1:0]),
      .cfg_initial_count (cfg_initial_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_grant_valid   (rsp_grant_valid),
      .rsp_grant_id      (rsp_grant_id),
      .rsp_all_free      (rsp_all_free),
      .rsp_waiter_count  (rsp_waiter_count)
   );

endmodule

// ===== rtl/csem_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting semaphore controller
// Sequences each transaction: capture of the request, then execution and
// loading of the result register once it is free.
// ----------------------------------------------------------------------------
module csem_ctrl
   import csem_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dp_stat_type dp_stat,
   output dp_cmd_type  dp_cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      req_stall       = 1'b1;
      dp_cmd.load_req = 1'b0;
      dp_cmd.commit   = 1'b0;
      unique case (state_ff)
         CS_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               dp_cmd.load_req = 1'b1;
               state_in        = CS_EXEC;
            end
         end
         CS_EXEC: begin
            if (dp_stat.slot_free) begin
               dp_cmd.commit = 1'b1;
               state_in      = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/csem_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting semaphore datapath
// Permit counter, waiter queue memory with its pointers, the configuration
// register and the result register.
// ----------------------------------------------------------------------------
module csem_datapath
   import csem_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dp_cmd_type            dp_cmd,
   output dp_stat_type           dp_stat,
   input  logic                  req_command,
   input  logic [ID_W-1:0]       req_requester_id,
   input  logic                  cfg_we,
   input  logic [COUNT_W-1:0]    cfg_wdata,
   output logic [COUNT_W-1:0]    cfg_initial_count,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [2:0]            rsp_status,
   output logic                  rsp_grant_valid,
   output logic [ID_W-1:0]       rsp_grant_id,
   output logic                  rsp_all_free,
   output logic [WAITERS_W-1:0]  rsp_waiter_count
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

   logic [ID_W-1:0]    waiter_mem [QUEUE_DEPTH];
   logic [ID_W-1:0]    rd_data_ff;

   command_type        cmd_ff;
   logic [ID_W-1:0]    id_ff;
   logic [COUNT_W-1:0] init_ff;
   logic [COUNT_W-1:0] free_ff;
   logic [COUNT_W-1:0] free_in;
   logic [PTR_W-1:0]   head_ff;
   logic [PTR_W-1:0]   head_in;
   logic [PTR_W-1:0]   tail_ff;
   logic [PTR_W-1:0]   tail_in;
   logic [OCC_W-1:0]   occ_ff;
   logic [OCC_W-1:0]   occ_in;
   logic               wr_en;

   status_type         sts;
   logic               gvalid;
   logic [ID_W-1:0]    gid;
   logic [OCC_W+WAITERS_W-1:0] occ_ext;

   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   status_type         rsp_status_ff;
   logic               rsp_grant_valid_ff;
   logic [ID_W-1:0]    rsp_grant_id_ff;
   logic               rsp_all_free_ff;
   logic [WAITERS_W-1:0] rsp_waiter_count_ff;

   assign dp_stat.slot_free = !rsp_valid_ff || !rsp_stall;
   assign cfg_initial_count = init_ff;

   always_ff @(posedge clock) begin
      if (dp_cmd.load_req) begin
         cmd_ff <= command_type'(req_command);
         id_ff  <= req_requester_id;
      end
   end

   always_comb begin
      free_in = free_ff;
      head_in = head_ff;
      tail_in = tail_ff;
      occ_in  = occ_ff;
      wr_en   = 1'b0;
      gvalid  = 1'b0;
      gid     = '0;
      sts     = STS_GRANTED;
      unique case (cmd_ff)
         CMD_ACQUIRE: begin
            priority if (free_ff != '0) begin
               free_in = free_ff - COUNT_W'(1);
               gvalid  = 1'b1;
               gid     = id_ff;
               sts     = STS_GRANTED;
            end else if (occ_ff == OCC_FULL) begin
               sts = STS_REJECTED;
            end else begin
               wr_en   = 1'b1;
               tail_in = (tail_ff == PTR_LAST) ? '0 : tail_ff + PTR_W'(1);
               occ_in  = occ_ff + OCC_W'(1);
               sts     = STS_QUEUED;
            end
         end
         CMD_RELEASE: begin
            priority if (occ_ff != '0) begin
               gid     = rd_data_ff;
               gvalid  = 1'b1;
               head_in = (head_ff == PTR_LAST) ? '0 : head_ff + PTR_W'(1);
               occ_in  = occ_ff - OCC_W'(1);
               sts     = STS_HANDED;
            end else if (free_ff >= init_ff) begin
               sts = STS_RELEASE_ERROR;
            end else begin
               free_in = free_ff + COUNT_W'(1);
               sts     = STS_RETURNED;
            end
         end
         default: begin
            sts = STS_RELEASE_ERROR;
         end
      endcase
   end

   assign occ_ext = {{WAITERS_W{1'b0}}, occ_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff <= INIT_COUNT_RESET;
         free_ff <= INIT_COUNT_RESET;
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
      end else if (cfg_we) begin
         init_ff <= cfg_wdata;
         free_ff <= cfg_wdata;
         head_ff <= '0;
         tail_ff <= '0;
         occ_ff  <= '0;
      end else if (dp_cmd.commit) begin
         free_ff <= free_in;
         head_ff <= head_in;
         tail_ff <= tail_in;
         occ_ff  <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.commit && wr_en) begin
         waiter_mem[tail_ff] <= id_ff;
      end
      rd_data_ff <= waiter_mem[head_ff];
   end

   always_comb begin
      if (dp_cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.commit) begin
         rsp_status_ff       <= sts;
         rsp_grant_valid_ff  <= gvalid;
         rsp_grant_id_ff     <= gid;
         rsp_all_free_ff     <= (free_in == init_ff);
         rsp_waiter_count_ff <= occ_ext[WAITERS_W-1:0];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_grant_valid  = rsp_grant_valid_ff;
   assign rsp_grant_id     = rsp_grant_id_ff;
   assign rsp_all_free     = rsp_all_free_ff;
   assign rsp_waiter_count = rsp_waiter_count_ff;

   a_occ_bounded: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_FULL)
      else $error("Waiter queue occupancy exceeds its depth.");

   a_free_bounded: assert property (@(posedge clock) disable iff (reset)
      free_ff <= init_ff)
      else $error("Free permit count exceeds the initial count.");

   a_waiters_hold_no_permit: assert property (@(posedge clock) disable iff (reset)
      occ_ff != '0 |-> free_ff == '0)
      else $error("Waiters are queued while a permit is free.");

   a_grant_status: assert property (@(posedge clock) disable iff (reset)
      dp_cmd.commit && gvalid |=> rsp_status_ff == STS_GRANTED
                                   || rsp_status_ff == STS_HANDED)
      else $error("A grant was issued with a status that grants nothing.");

endmodule
